[rtl/sorted_timer_queue_defines.svh]
// assertion macros shared by the timer queue rtl
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication
`define STQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer queue check failed");

// next-cycle implication
`define STQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer queue check failed");

`endif

[rtl/stq_pkg.sv]
package stq_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 16;
   localparam int unsigned MAX_RESULTS      = 16;
   localparam int unsigned POP_CNT_W        = $clog2(MAX_RESULTS);
   localparam int unsigned CMD_W            = 2;
   localparam int unsigned TAG_W            = 16;
   localparam int unsigned TIME_W           = 32;
   localparam int unsigned STATUS_W         = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_ADJUST = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_TICK   = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_DUP     = 3'd2,
      ST_MISSING = 3'd3,
      ST_NONE    = 3'd4
   } status_type;

   // what every cell of the chain does in a cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PLACE  = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   // broadcast from the sequencer to all cells
   typedef struct packed {
      cell_op_type       op;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] expiry;
   } cell_ctl_type;

endpackage

[rtl/stq_req_if.sv]
interface stq_req_if;
   logic                             valid;
   logic                             ready;
   logic [stq_pkg::CMD_W-1:0]        command;
   logic [stq_pkg::TAG_W-1:0]        timer_tag;
   logic [stq_pkg::TIME_W-1:0]       expire_time;
   logic [stq_pkg::TIME_W-1:0]       current_time;

   modport source (output valid, command, timer_tag, expire_time, current_time,
                   input ready);
   modport sink   (input valid, command, timer_tag, expire_time, current_time,
                   output ready);
endinterface

[rtl/stq_rsp_if.sv]
interface stq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [stq_pkg::STATUS_W-1:0]     status;
   logic [stq_pkg::TAG_W-1:0]        expired_tag;
   logic                             expired_valid;
   logic                             last;

   modport source (output valid, status, expired_tag, expired_valid, last,
                   input ready);
   modport sink   (input valid, status, expired_tag, expired_valid, last,
                   output ready);
endinterface

[rtl/stq_cell.sv]
module stq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stq_pkg::cell_ctl_type ctl,
   input  stq_pkg::entry_type    left_entry,
   input  logic                  left_ins,
   input  stq_pkg::entry_type    right_entry,
   input  logic                  seen_in,
   output stq_pkg::entry_type    entry,
   output logic                  ins_out,
   output logic                  seen_out,
   output logic                  match
);

   stq_pkg::entry_type entry_ff;
   stq_pkg::entry_type entry_in;
   stq_pkg::entry_type fresh;

   // tag lookup and removal point travel left to right
   assign match    = entry_ff.valid && (entry_ff.tag == ctl.tag);
   assign seen_out = seen_in || match;

   // new timer belongs here or earlier: empty slot or strictly later expiry
   assign ins_out = !entry_ff.valid || (entry_ff.expiry > ctl.expiry);

   assign fresh = '{valid: 1'b1, tag: ctl.tag, expiry: ctl.expiry};

   // shift left on removal, shift right or take the new timer on placement
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         stq_pkg::OP_REMOVE: begin
            if (seen_out) begin
               entry_in = right_entry;
            end
         end
         stq_pkg::OP_PLACE: begin
            if (ins_out) begin
               entry_in = left_ins ? left_entry : fresh;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

[rtl/sorted_timer_queue.sv]
// channel   modport   beat carries
// req_bus   sink      command, timer_tag, expire_time, current_time
// rsp_bus   source    status, expired_tag, expired_valid, last
//
// insert and delete take one pass through the cell chain, adjust a remove
// pass then a place pass, tick one remove pass per popped timer (up to 16)
// or a single status beat when nothing is due. each pass is one shift of the chain.
// reset clears the sequencer, the response valid and every cell's valid bit.
// a stalled response holds the sequencer; a new request is taken once the
// final response of the previous one sits in the output register.
`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue #(
   parameter int unsigned CAPACITY = stq_pkg::CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   stq_req_if.sink    req_bus,
   stq_rsp_if.source  rsp_bus
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_LOOK  = 4'b0010,
      S_PLACE = 4'b0100,
      S_POP   = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   stq_pkg::command_type               cmd_ff;
   logic [stq_pkg::TAG_W-1:0]          tag_ff;
   logic [stq_pkg::TIME_W-1:0]         exp_ff;
   logic [stq_pkg::TIME_W-1:0]         now_ff;
   logic [stq_pkg::POP_CNT_W-1:0]      pop_cnt_ff, pop_cnt_in;

   logic                               rsp_valid_ff;
   stq_pkg::status_type                rsp_status_ff;
   logic [stq_pkg::TAG_W-1:0]          rsp_tag_ff;
   logic                               rsp_exp_valid_ff;
   logic                               rsp_last_ff;

   logic                               emit;
   stq_pkg::status_type                emit_status;
   logic [stq_pkg::TAG_W-1:0]          emit_tag;
   logic                               emit_exp_valid;
   logic                               emit_last;

   stq_pkg::cell_ctl_type              ctl;
   logic                               seen_first;
   stq_pkg::entry_type                 entries [CAPACITY];
   logic [CAPACITY-1:0]                valid_vec;
   logic [CAPACITY-1:0]                match_vec;
   logic [CAPACITY-1:0]                ins_vec;
   logic [CAPACITY:0]                  seen_vec;

   logic                               req_fire;
   logic                               out_free;
   logic                               any_match;
   logic                               full;
   logic                               head_due;
   logic                               next_due;
   logic                               pop_fire;
   logic                               pop_last;

   assign seen_vec[0] = seen_first;

   // the chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      stq_pkg::entry_type left_e;
      stq_pkg::entry_type right_e;
      logic               left_i;

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_i = 1'b0;
      end else begin : g_inner
         assign left_e = entries[i-1];
         assign left_i = ins_vec[i-1];
      end

      if (i == CAPACITY-1) begin : g_last
         assign right_e = '0;
      end else begin : g_body
         assign right_e = entries[i+1];
      end

      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_e),
         .left_ins    (left_i),
         .right_entry (right_e),
         .seen_in     (seen_vec[i]),
         .entry       (entries[i]),
         .ins_out     (ins_vec[i]),
         .seen_out    (seen_vec[i+1]),
         .match       (match_vec[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   // status seen from the chain
   assign any_match = |match_vec;
   assign full      = valid_vec[CAPACITY-1];
   assign head_due  = valid_vec[0] && (entries[0].expiry <= now_ff);
   assign next_due  = valid_vec[1] && (entries[1].expiry <= now_ff);
   assign pop_last  = (pop_cnt_ff == stq_pkg::POP_CNT_W'(stq_pkg::MAX_RESULTS - 1))
                      || !next_due;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign pop_fire = (state_ff == S_POP) && out_free && head_due;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      pop_cnt_in     = pop_cnt_ff;
      ctl.op         = stq_pkg::OP_HOLD;
      ctl.tag        = tag_ff;
      ctl.expiry     = exp_ff;
      seen_first     = 1'b0;
      emit           = 1'b0;
      emit_status    = stq_pkg::ST_OK;
      emit_tag       = '0;
      emit_exp_valid = 1'b0;
      emit_last      = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pop_cnt_in = '0;
               state_in   = (stq_pkg::command_type'(req_bus.command) == stq_pkg::CMD_TICK)
                            ? S_POP : S_LOOK;
            end
         end
         S_LOOK: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (cmd_ff)
                  stq_pkg::CMD_INSERT: begin
                     emit = 1'b1;
                     if (any_match) begin
                        emit_status = stq_pkg::ST_DUP;
                     end else if (full) begin
                        emit_status = stq_pkg::ST_FULL;
                     end else begin
                        ctl.op = stq_pkg::OP_PLACE;
                     end
                  end
                  stq_pkg::CMD_ADJUST: begin
                     if (any_match) begin
                        ctl.op   = stq_pkg::OP_REMOVE;
                        state_in = S_PLACE;
                     end else begin
                        emit        = 1'b1;
                        emit_status = stq_pkg::ST_MISSING;
                     end
                  end
                  stq_pkg::CMD_DELETE: begin
                     emit = 1'b1;
                     if (any_match) begin
                        ctl.op = stq_pkg::OP_REMOVE;
                     end else begin
                        emit_status = stq_pkg::ST_MISSING;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PLACE: begin
            if (out_free) begin
               ctl.op   = stq_pkg::OP_PLACE;
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               emit = 1'b1;
               if (head_due) begin
                  ctl.op         = stq_pkg::OP_REMOVE;
                  seen_first     = 1'b1;
                  emit_tag       = entries[0].tag;
                  emit_exp_valid = 1'b1;
                  emit_last      = pop_last;
                  pop_cnt_in     = pop_cnt_ff + 1'b1;
                  if (pop_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  emit_status = stq_pkg::ST_NONE;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture, pop count and response payload
   always_ff @(posedge clock) begin
      pop_cnt_ff <= pop_cnt_in;
      if (req_fire) begin
         cmd_ff <= stq_pkg::command_type'(req_bus.command);
         tag_ff <= req_bus.timer_tag;
         exp_ff <= req_bus.expire_time;
         now_ff <= req_bus.current_time;
      end
      if (emit) begin
         rsp_status_ff    <= emit_status;
         rsp_tag_ff       <= emit_tag;
         rsp_exp_valid_ff <= emit_exp_valid;
         rsp_last_ff      <= emit_last;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.expired_tag   = rsp_tag_ff;
   assign rsp_bus.expired_valid = rsp_exp_valid_ff;
   assign rsp_bus.last          = rsp_last_ff;

   // held timers always occupy a packed run of cells from the head
   `STQ_ASSERT_IMP(a_packed_run, clock, reset, 1'b1, (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
   // tags are unique, so a lookup hits at most one cell
   `STQ_ASSERT_IMP(a_unique_hit, clock, reset, 1'b1, $onehot0(match_vec))
   // adjust removed its timer first, so the place pass always has room
   `STQ_ASSERT_IMP(a_room_to_place, clock, reset, state_ff == S_PLACE, !full)
   // a pop frees the last cell
   `STQ_ASSERT_NXT(a_pop_frees_top, clock, reset, pop_fire, !valid_vec[CAPACITY-1])

endmodule

[tb/sv/tb_sorted_timer_queue.sv]
module tb_sorted_timer_queue;

   localparam int unsigned QUEUE_DEPTH  = stq_pkg::CAPACITY_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 404;
   localparam int unsigned TAG_POOL     = 20;
   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned HOLD_AT_BEAT = 80;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned DRAIN_CYCLES = 40;

   typedef struct packed {
      stq_pkg::command_type       cmd;
      logic [stq_pkg::TAG_W-1:0]  tag;
      logic [stq_pkg::TIME_W-1:0] expiry;
      logic [stq_pkg::TIME_W-1:0] cur_time;
   } timer_cmd_type;

   typedef struct {
      logic [stq_pkg::TAG_W-1:0]  tag;
      logic [stq_pkg::TIME_W-1:0] expiry;
   } timer_entry_type;

   typedef struct {
      stq_pkg::status_type       status;
      logic [stq_pkg::TAG_W-1:0] tag;
      logic                      valid;
      logic                      last;
   } timer_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stq_req_if req_bus ();
   stq_rsp_if rsp_bus ();

   sorted_timer_queue #(
      .CAPACITY (QUEUE_DEPTH)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // commands still to be sent, the shadow timer list and the beats it predicts
   timer_cmd_type   pending_cmds[$];
   timer_entry_type timer_list[$];
   timer_beat_type  expected_beats[$];

   timer_cmd_type   live_cmd;
   timer_cmd_type   took_cmd;
   logic            took_flag = 1'b0;
   int unsigned     req_gap = 0;
   int unsigned     cmds_launched = 0;
   int unsigned     rsp_wait = 0;
   int unsigned     beats_seen = 0;
   int unsigned     hold_left = 0;
   logic            hold_started = 1'b0;
   int unsigned     idle_cycles = 0;
   int unsigned     fail_count = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle draw: every third stretch of beats runs with no gaps
   function automatic int unsigned draw_idle(int unsigned n, int unsigned span);
      if ((n / span) % 3 == 2) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic void queue_cmd(stq_pkg::command_type cmd,
                                     logic [stq_pkg::TAG_W-1:0] tag,
                                     logic [stq_pkg::TIME_W-1:0] expiry,
                                     logic [stq_pkg::TIME_W-1:0] cur_time);
      timer_cmd_type c;
      c.cmd      = cmd;
      c.tag      = tag;
      c.expiry   = expiry;
      c.cur_time = cur_time;
      pending_cmds.push_back(c);
   endfunction

   // new timer goes after every timer with an equal or earlier expiry
   function automatic void place_timer(logic [stq_pkg::TAG_W-1:0] tag,
                                       logic [stq_pkg::TIME_W-1:0] expiry);
      timer_entry_type e;
      int pos;
      pos = 0;
      while (pos < timer_list.size() && timer_list[pos].expiry <= expiry) pos++;
      e.tag    = tag;
      e.expiry = expiry;
      timer_list.insert(pos, e);
   endfunction

   function automatic void push_status(stq_pkg::status_type st);
      timer_beat_type b;
      b.status = st;
      b.tag    = '0;
      b.valid  = 1'b0;
      b.last   = 1'b1;
      expected_beats.push_back(b);
   endfunction

   // driver: one command beat at a time, gap drawn per command
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         took_flag     <= 1'b0;
         req_gap       <= 0;
      end else begin
         took_flag <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) took_cmd <= live_cmd;
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_bus.valid <= 1'b0;
               req_gap       <= req_gap - 1;
            end else if (pending_cmds.size() != 0) begin
               live_cmd = pending_cmds.pop_front();
               req_bus.command      <= live_cmd.cmd;
               req_bus.timer_tag    <= live_cmd.tag;
               req_bus.expire_time  <= live_cmd.expiry;
               req_bus.current_time <= live_cmd.cur_time;
               req_bus.valid        <= 1'b1;
               req_gap              <= draw_idle(cmds_launched, 40);
               cmds_launched++;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // expected beats of each accepted command, worked out on the falling clock edge
   always @(negedge clock) begin : timer_predict
      int pos;
      int popped;
      timer_beat_type b;
      if (took_flag) begin
         pos = -1;
         foreach (timer_list[i]) begin
            if (pos < 0 && timer_list[i].tag == took_cmd.tag) pos = i;
         end
         case (took_cmd.cmd)
            stq_pkg::CMD_TICK: begin
               popped = 0;
               while (popped < stq_pkg::MAX_RESULTS && timer_list.size() != 0 &&
                      timer_list[0].expiry <= took_cmd.cur_time) begin
                  b.status = stq_pkg::ST_OK;
                  b.tag    = timer_list[0].tag;
                  b.valid  = 1'b1;
                  b.last   = 1'b0;
                  expected_beats.push_back(b);
                  void'(timer_list.pop_front());
                  popped++;
               end
               if (popped == 0) push_status(stq_pkg::ST_NONE);
               else expected_beats[$].last = 1'b1;
            end
            stq_pkg::CMD_INSERT: begin
               if (pos >= 0) begin
                  push_status(stq_pkg::ST_DUP);
               end else if (timer_list.size() >= QUEUE_DEPTH) begin
                  push_status(stq_pkg::ST_FULL);
               end else begin
                  place_timer(took_cmd.tag, took_cmd.expiry);
                  push_status(stq_pkg::ST_OK);
               end
            end
            stq_pkg::CMD_ADJUST: begin
               if (pos < 0) begin
                  push_status(stq_pkg::ST_MISSING);
               end else begin
                  timer_list.delete(pos);
                  place_timer(took_cmd.tag, took_cmd.expiry);
                  push_status(stq_pkg::ST_OK);
               end
            end
            default: begin
               if (pos < 0) begin
                  push_status(stq_pkg::ST_MISSING);
               end else begin
                  timer_list.delete(pos);
                  push_status(stq_pkg::ST_OK);
               end
            end
         endcase
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin : beat_check
      timer_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait = 0;
         beats_seen <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: status %0d tag %h",
                      rsp_bus.status, rsp_bus.expired_tag);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_bus.status);
                  fail_count++;
               end
               if (rsp_bus.expired_tag !== want.tag) begin
                  $error("expired_tag expected %h got %h", want.tag, rsp_bus.expired_tag);
                  fail_count++;
               end
               if (rsp_bus.expired_valid !== want.valid) begin
                  $error("expired_valid expected %0d got %0d", want.valid,
                         rsp_bus.expired_valid);
                  fail_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_bus.last);
                  fail_count++;
               end
            end
            beats_seen <= beats_seen + 1;
            rsp_wait = draw_idle(beats_seen, 50);
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_bus.ready <= (rsp_wait == 0) && (hold_left == 0);
      end
   end

   // one long receiver hold-off so the block backs up onto its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         hold_started <= 1'b0;
      end else if (!hold_started && beats_seen >= HOLD_AT_BEAT) begin
         hold_left    <= HOLD_CYCLES;
         hold_started <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus, then drain and verdict
   initial begin
      logic [stq_pkg::TAG_W-1:0]  tag_pool[TAG_POOL];
      logic [stq_pkg::TIME_W-1:0] gen_time;
      logic [stq_pkg::TIME_W-1:0] burst_expiry;
      logic [stq_pkg::TAG_W-1:0]  tag;
      logic [stq_pkg::TIME_W-1:0] expiry;
      int unsigned                random_items;
      int unsigned                pick;
      int unsigned                burst_len;

      // directed: empty tick, unknown tags, fill to capacity, full and duplicate,
      // adjust earlier and later, delete, ticks that pop part and then all
      queue_cmd(stq_pkg::CMD_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_DELETE, 16'h5A5A, 32'h0000_0000, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_ADJUST, 16'h5A5A, 32'h0000_0010, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_INSERT, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_INSERT, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      for (int k = 1; k <= 14; k++) begin
         queue_cmd(stq_pkg::CMD_INSERT, stq_pkg::TAG_W'(k * 16'h1111),
                   (k < 8) ? 32'd100 : 32'h8000_0000 + k, $urandom);
      end
      queue_cmd(stq_pkg::CMD_INSERT, 16'h1234, 32'h0000_0005, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_INSERT, 16'hFFFF, 32'h0000_0005, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_ADJUST, 16'h0000, 32'd50, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_ADJUST, 16'hFFFF, 32'd200, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_DELETE, 16'h3333, 32'h0000_0000, 32'h0000_0000);
      queue_cmd(stq_pkg::CMD_TICK, 16'h0000, 32'h0000_0000, 32'd100);
      queue_cmd(stq_pkg::CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // random: mostly a small tag pool so hits, duplicates and fills are common
      foreach (tag_pool[i]) tag_pool[i] = stq_pkg::TAG_W'($urandom);
      gen_time     = $urandom;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         tag  = (pick < 85) ? tag_pool[$urandom_range(0, TAG_POOL - 1)]
                            : stq_pkg::TAG_W'($urandom);
         case ($urandom_range(0, 19))
            0, 1:    expiry = $urandom;
            2:       expiry = '0;
            3:       expiry = '1;
            default: expiry = gen_time + $urandom_range(0, 60);
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            if ($urandom_range(0, 9) == 0) begin
               // burst of equal expiries from distinct pool tags
               burst_len    = $urandom_range(3, 8);
               burst_expiry = gen_time + $urandom_range(0, 30);
               pick         = $urandom_range(0, TAG_POOL - 1);
               for (int j = 0; j < burst_len; j++) begin
                  queue_cmd(stq_pkg::CMD_INSERT, tag_pool[(pick + j) % TAG_POOL],
                            burst_expiry, $urandom);
               end
               random_items += burst_len;
            end else begin
               queue_cmd(stq_pkg::CMD_INSERT, tag, expiry, $urandom);
               random_items++;
            end
         end else if (pick < 58) begin
            queue_cmd(stq_pkg::CMD_ADJUST, tag, expiry, $urandom);
            random_items++;
         end else if (pick < 73) begin
            queue_cmd(stq_pkg::CMD_DELETE, tag, $urandom, $urandom);
            random_items++;
         end else begin
            gen_time = gen_time + $urandom_range(0, 25);
            queue_cmd(stq_pkg::CMD_TICK, stq_pkg::TAG_W'($urandom), $urandom,
                      ($urandom_range(0, 19) == 0) ? stq_pkg::TIME_W'($urandom) : gen_time);
            random_items++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || took_flag ||
             expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_req_if.sv
rtl/stq_rsp_if.sv
rtl/stq_cell.sv
rtl/sorted_timer_queue.sv
tb/sv/tb_sorted_timer_queue.sv
